>>> hdl/j2g_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and normalization helper for the j2 acceleration pipeline
package j2g_pkg;

	localparam int EXP_W = 12;
	localparam int FN_W  = 1 + EXP_W + 32;

	// sign, binary exponent, 32-bit significand with top bit set (or zero)
	typedef struct packed {
		logic                    s;
		logic signed [EXP_W-1:0] e;
		logic [31:0]             m;
	} fnum_t;

	typedef enum logic [1:0] {
		CFG_GRAV   = 2'd0,
		CFG_J2     = 2'd1,
		CFG_RADIUS = 2'd2,
		CFG_NONE   = 2'd3
	} cfg_idx_t;

	localparam int DEF_POS_WIDTH = 40;
	localparam int DEF_ACC_WIDTH = 48;

	localparam logic [39:0] GRAV_RST   = 40'd398600;
	localparam logic [31:0] J2_RST     = 32'd1190364274;
	localparam logic [39:0] RADIUS_RST = 40'd26124849;

	localparam fnum_t F_THREE = '{s: 1'b0, e: EXP_W'(-30), m: 32'hC000_0000};
	localparam fnum_t F_FIVE  = '{s: 1'b0, e: EXP_W'(-29), m: 32'hA000_0000};

	// cycles from accept to result strobe
	localparam int LATENCY = 83;

	function automatic fnum_t norm64(input logic [63:0] mag, input logic sgn);
		fnum_t      r;
		logic [5:0] n;
		logic [63:0] sh;
		n = '0;
		for (int i = 0; i < 64; i++) begin
			if (mag[i]) n = 6'(i);
		end
		sh = mag << (6'd63 - n);
		r.s = sgn;
		if (mag == '0) begin
			r.m = '0;
			r.e = '0;
		end else begin
			r.m = sh[63:32];
			r.e = EXP_W'(n) - EXP_W'(31);
		end
		return r;
	endfunction

endpackage

>>> hdl/j2g_delay.sv
`timescale 1ns / 1ps
// fixed-length shift line that keeps operands aligned between units
module j2g_delay #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] tap_q [N];

	always_ff @(posedge clk) begin
		tap_q[0] <= d;
		for (int k = 1; k < N; k++) begin
			tap_q[k] <= tap_q[k-1];
		end
	end

	assign q = tap_q[N-1];
endmodule

>>> hdl/j2g_fmul.sv
`timescale 1ns / 1ps
// two-stage significand multiplier: product register, then normalize
module j2g_fmul (
	input  logic            clk,
	input  j2g_pkg::fnum_t  a,
	input  j2g_pkg::fnum_t  b,
	output j2g_pkg::fnum_t  y
);
	import j2g_pkg::*;

	logic [63:0]             prod_s1;
	logic signed [EXP_W-1:0] esum_s1;
	logic                    sgn_s1;
	logic                    zero_s1;
	fnum_t                   y_s2;

	always_ff @(posedge clk) begin
		prod_s1 <= {32'd0, a.m} * {32'd0, b.m};
		esum_s1 <= a.e + b.e;
		sgn_s1  <= a.s ^ b.s;
		zero_s1 <= (a.m == '0) || (b.m == '0);
	end

	always_ff @(posedge clk) begin
		if (zero_s1) begin
			y_s2 <= '0;
		end else if (prod_s1[63]) begin
			y_s2 <= '{s: sgn_s1, e: esum_s1 + EXP_W'(32), m: prod_s1[63:32]};
		end else begin
			y_s2 <= '{s: sgn_s1, e: esum_s1 + EXP_W'(31), m: prod_s1[62:31]};
		end
	end

	assign y = y_s2;
endmodule

>>> hdl/j2g_fadd.sv
`timescale 1ns / 1ps
// three-stage adder: align, add or subtract magnitudes, renormalize
module j2g_fadd (
	input  logic            clk,
	input  j2g_pkg::fnum_t  a,
	input  j2g_pkg::fnum_t  b,
	output j2g_pkg::fnum_t  y
);
	import j2g_pkg::*;

	logic                    a_big;
	fnum_t                   big, sml;
	logic [EXP_W:0]          shamt;
	logic [63:0]             av, bv;

	logic [63:0]             av_s1, bv_s1;
	logic                    sub_s1, sgn_s1, byp_s1;
	logic signed [EXP_W-1:0] be_s1;
	fnum_t                   bypv_s1;

	logic [63:0]             sum_s2;
	logic                    sgn_s2, byp_s2;
	logic signed [EXP_W-1:0] be_s2;
	fnum_t                   bypv_s2;

	fnum_t                   nv;
	fnum_t                   y_s3;

	always_comb begin
		a_big = (a.e > b.e) || ((a.e == b.e) && (a.m >= b.m));
		big   = a_big ? a : b;
		sml   = a_big ? b : a;
		shamt = {big.e[EXP_W-1], big.e} - {sml.e[EXP_W-1], sml.e};
		av    = {1'b0, big.m, 31'd0};
		bv    = (shamt >= (EXP_W+1)'(63)) ? 64'd0 : ({1'b0, sml.m, 31'd0} >> shamt);
	end

	always_ff @(posedge clk) begin
		av_s1   <= av;
		bv_s1   <= bv;
		sub_s1  <= big.s ^ sml.s;
		sgn_s1  <= big.s;
		be_s1   <= big.e;
		byp_s1  <= (a.m == '0) || (b.m == '0);
		bypv_s1 <= (a.m == '0) ? b : a;
	end

	always_ff @(posedge clk) begin
		sum_s2  <= sub_s1 ? (av_s1 - bv_s1) : (av_s1 + bv_s1);
		sgn_s2  <= sgn_s1;
		be_s2   <= be_s1;
		byp_s2  <= byp_s1;
		bypv_s2 <= bypv_s1;
	end

	assign nv = norm64(sum_s2, sgn_s2);

	always_ff @(posedge clk) begin
		if (byp_s2) begin
			y_s3 <= bypv_s2;
		end else if (nv.m == '0) begin
			y_s3 <= nv;
		end else begin
			y_s3 <= '{s: nv.s, e: nv.e + be_s2 - EXP_W'(31), m: nv.m};
		end
	end

	assign y = y_s3;
endmodule

>>> hdl/j2g_fsqrt.sv
`timescale 1ns / 1ps
// square root, one result bit per pipeline stage over 32 stages
module j2g_fsqrt (
	input  logic            clk,
	input  j2g_pkg::fnum_t  a,
	output j2g_pkg::fnum_t  y
);
	import j2g_pkg::*;

	localparam int NSTEP = 32;

	logic [63:0]             m_in;
	logic signed [EXP_W-1:0] ev;

	logic [33:0]             rem_s  [NSTEP];
	logic [31:0]             res_s  [NSTEP];
	logic [63:0]             mv_s   [NSTEP];
	logic signed [EXP_W-1:0] eh_s   [NSTEP];
	logic                    zero_s [NSTEP];

	// make the exponent even before taking the root
	always_comb begin
		if (a.e[0]) begin
			m_in = {1'b0, a.m, 31'd0};
			ev   = a.e - EXP_W'(31);
		end else begin
			m_in = {a.m, 32'd0};
			ev   = a.e - EXP_W'(32);
		end
	end

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		logic [33:0]             rem_in;
		logic [31:0]             res_in;
		logic [63:0]             mv_in;
		logic signed [EXP_W-1:0] eh_in;
		logic                    zero_in;
		logic [35:0]             cur, trial;
		logic                    take;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign res_in  = '0;
			assign mv_in   = m_in;
			assign eh_in   = ev >>> 1;
			assign zero_in = (a.m == '0);
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign res_in  = res_s[k-1];
			assign mv_in   = mv_s[k-1];
			assign eh_in   = eh_s[k-1];
			assign zero_in = zero_s[k-1];
		end

		always_comb begin
			cur   = {rem_in, mv_in[63:62]};
			trial = {2'b00, res_in, 2'b01};
			take  = (cur >= trial);
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? 34'(cur - trial) : cur[33:0];
			res_s[k]  <= {res_in[30:0], take};
			mv_s[k]   <= {mv_in[61:0], 2'b00};
			eh_s[k]   <= eh_in;
			zero_s[k] <= zero_in;
		end
	end

	assign y = zero_s[NSTEP-1] ? '0 :
		'{s: 1'b0, e: eh_s[NSTEP-1], m: res_s[NSTEP-1]};
endmodule

>>> hdl/j2g_fdiv.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per stage, then renormalize
module j2g_fdiv (
	input  logic            clk,
	input  j2g_pkg::fnum_t  a,
	input  j2g_pkg::fnum_t  b,
	output j2g_pkg::fnum_t  y
);
	import j2g_pkg::*;

	localparam int NSTEP = 32;

	logic [31:0]             rem_s  [NSTEP+1];
	logic [32:0]             quo_s  [NSTEP+1];
	logic [31:0]             dv_s   [NSTEP+1];
	logic signed [EXP_W-1:0] e_s    [NSTEP+1];
	logic                    sg_s   [NSTEP+1];
	logic                    zero_s [NSTEP+1];
	fnum_t                   y_q;

	// top quotient bit straight from comparing the significands
	always_ff @(posedge clk) begin
		rem_s[0]  <= (a.m >= b.m) ? (a.m - b.m) : a.m;
		quo_s[0]  <= {32'd0, (a.m >= b.m)};
		dv_s[0]   <= b.m;
		e_s[0]    <= a.e - b.e;
		sg_s[0]   <= a.s ^ b.s;
		zero_s[0] <= (a.m == '0) || (b.m == '0);
	end

	for (genvar k = 1; k <= NSTEP; k++) begin : g_step
		logic [32:0] t;
		logic        take;

		always_comb begin
			t    = {rem_s[k-1], 1'b0};
			take = (t >= {1'b0, dv_s[k-1]});
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? 32'(t - {1'b0, dv_s[k-1]}) : t[31:0];
			quo_s[k]  <= {quo_s[k-1][31:0], take};
			dv_s[k]   <= dv_s[k-1];
			e_s[k]    <= e_s[k-1];
			sg_s[k]   <= sg_s[k-1];
			zero_s[k] <= zero_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (zero_s[NSTEP]) begin
			y_q <= '0;
		end else if (quo_s[NSTEP][32]) begin
			y_q <= '{s: sg_s[NSTEP], e: e_s[NSTEP] - EXP_W'(31), m: quo_s[NSTEP][32:1]};
		end else begin
			y_q <= '{s: sg_s[NSTEP], e: e_s[NSTEP] - EXP_W'(32), m: quo_s[NSTEP][31:0]};
		end
	end

	assign y = y_q;
endmodule

>>> hdl/j2_zonal_gravity_accel.sv
`timescale 1ns / 1ps
// j2 zonal gravity acceleration, fully pipelined top level
//
// channel   ports                                  handshake
// input     pos_x, pos_y, pos_z                    start, busy
// result    acc_x, acc_y, acc_z, calc_error        done
// config    cfg_index, cfg_data                    cfg_valid, cfg_ready
//
// one position per cycle; each result is marked by a done strobe.
// latency is set by the 32-stage square root and the 34-stage divider in series.
// busy and cfg_ready stay low and high; done is a one-cycle strobe.
// arst_n clears the valid line and loads the register reset values.
// the receiver cannot stall, so nothing in the pipeline ever holds.
module j2_zonal_gravity_accel #(
	parameter int POS_WIDTH = j2g_pkg::DEF_POS_WIDTH,
	parameter int ACC_WIDTH = j2g_pkg::DEF_ACC_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [POS_WIDTH-1:0] pos_x,
	input  logic signed [POS_WIDTH-1:0] pos_y,
	input  logic signed [POS_WIDTH-1:0] pos_z,
	output logic                        done,
	output logic signed [ACC_WIDTH-1:0] acc_x,
	output logic signed [ACC_WIDTH-1:0] acc_y,
	output logic signed [ACC_WIDTH-1:0] acc_z,
	output logic                        calc_error,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  j2g_pkg::cfg_idx_t           cfg_index,
	input  logic [39:0]                 cfg_data
);
	import j2g_pkg::*;

	localparam int VLD_N = LATENCY - 1;

	logic [39:0] grav_q;
	logic [31:0] j2_q;
	logic [39:0] radius_q;

	fnum_t kj_q, kmu_q, kr_q;
	fnum_t k_jm, k_jmr, k_jmrr, k_all, k_eff;
	logic [32:0] jmag;

	logic [POS_WIDTH-1:0] mx_s1, my_s1, mz_s1;
	logic                 nx_s1, ny_s1, nz_s1, zero_s1;
	fnum_t                fx_s2, fy_s2, fz_s2;

	logic [VLD_N-1:0] vld_q;

	fnum_t xx, yy, zz, sxy, zz_d, q, r, qq, qq_d, q_d, den1, den;
	fnum_t z5, nz5, nz5_d4, nz5_d6, bx, q3, bz;
	fnum_t x_d, y_d, z_d, numx, numy, numz, numx_d, numy_d, numz_d;
	fnum_t quox, quoy, quoz, ax, ay, az;
	logic  zero_d;

	logic [ACC_WIDTH:0] ox, oy, oz;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q   <= GRAV_RST;
			j2_q     <= J2_RST;
			radius_q <= RADIUS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GRAV:   grav_q   <= cfg_data;
				CFG_J2:     j2_q     <= cfg_data[31:0];
				CFG_RADIUS: radius_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// scale factor chain runs off the registers and settles long before use
	assign jmag = j2_q[31] ? (33'h1_0000_0000 - {1'b0, j2_q}) : {1'b0, j2_q};

	always_ff @(posedge clk) begin
		kj_q  <= norm64(64'(jmag), j2_q[31]);
		kmu_q <= norm64(64'(grav_q), 1'b0);
		kr_q  <= norm64(64'(radius_q), 1'b0);
	end

	j2g_fmul u_k1 (.clk(clk), .a(kj_q),   .b(kmu_q),   .y(k_jm));
	j2g_fmul u_k2 (.clk(clk), .a(k_jm),   .b(kr_q),    .y(k_jmr));
	j2g_fmul u_k3 (.clk(clk), .a(k_jmr),  .b(kr_q),    .y(k_jmrr));
	j2g_fmul u_k4 (.clk(clk), .a(k_jmrr), .b(F_THREE), .y(k_all));

	// negate and scale by 2^31
	assign k_eff = '{s: ~k_all.s, e: k_all.e + EXP_W'(31), m: k_all.m};

	// input magnitudes, then normalize
	always_ff @(posedge clk) begin
		mx_s1   <= pos_x[POS_WIDTH-1] ? POS_WIDTH'(-pos_x) : POS_WIDTH'(pos_x);
		my_s1   <= pos_y[POS_WIDTH-1] ? POS_WIDTH'(-pos_y) : POS_WIDTH'(pos_y);
		mz_s1   <= pos_z[POS_WIDTH-1] ? POS_WIDTH'(-pos_z) : POS_WIDTH'(pos_z);
		nx_s1   <= pos_x[POS_WIDTH-1];
		ny_s1   <= pos_y[POS_WIDTH-1];
		nz_s1   <= pos_z[POS_WIDTH-1];
		zero_s1 <= (pos_x == '0) && (pos_y == '0) && (pos_z == '0);
	end

	always_ff @(posedge clk) begin
		fx_s2 <= norm64(64'(mx_s1), nx_s1);
		fy_s2 <= norm64(64'(my_s1), ny_s1);
		fz_s2 <= norm64(64'(mz_s1), nz_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[VLD_N-2:0], start && !busy};
		end
	end

	// squares and q = x^2 + y^2 + z^2
	j2g_fmul u_xx (.clk(clk), .a(fx_s2), .b(fx_s2), .y(xx));
	j2g_fmul u_yy (.clk(clk), .a(fy_s2), .b(fy_s2), .y(yy));
	j2g_fmul u_zz (.clk(clk), .a(fz_s2), .b(fz_s2), .y(zz));
	j2g_fadd u_sxy (.clk(clk), .a(xx), .b(yy), .y(sxy));
	j2g_delay #(.W(FN_W), .N(3)) u_dzz (.clk(clk), .d(zz), .q(zz_d));
	j2g_fadd u_q (.clk(clk), .a(sxy), .b(zz_d), .y(q));

	// denominator r^7 as ((q*q)*r)*q
	j2g_fsqrt u_r (.clk(clk), .a(q), .y(r));
	j2g_fmul u_qq (.clk(clk), .a(q), .b(q), .y(qq));
	j2g_delay #(.W(FN_W), .N(30)) u_dqq (.clk(clk), .d(qq), .q(qq_d));
	j2g_fmul u_den1 (.clk(clk), .a(qq_d), .b(r), .y(den1));
	j2g_delay #(.W(FN_W), .N(34)) u_dq (.clk(clk), .d(q), .q(q_d));
	j2g_fmul u_den (.clk(clk), .a(den1), .b(q_d), .y(den));

	// q - 5z^2 and 3q - 5z^2
	j2g_fmul u_z5 (.clk(clk), .a(F_FIVE), .b(zz), .y(z5));
	assign nz5 = '{s: ~z5.s, e: z5.e, m: z5.m};
	j2g_delay #(.W(FN_W), .N(4)) u_dz5a (.clk(clk), .d(nz5), .q(nz5_d4));
	j2g_delay #(.W(FN_W), .N(2)) u_dz5b (.clk(clk), .d(nz5_d4), .q(nz5_d6));
	j2g_fadd u_bx (.clk(clk), .a(q), .b(nz5_d4), .y(bx));
	j2g_fmul u_q3 (.clk(clk), .a(F_THREE), .b(q), .y(q3));
	j2g_fadd u_bz (.clk(clk), .a(q3), .b(nz5_d6), .y(bz));

	// numerators
	j2g_delay #(.W(FN_W), .N(11)) u_dx (.clk(clk), .d(fx_s2), .q(x_d));
	j2g_delay #(.W(FN_W), .N(11)) u_dy (.clk(clk), .d(fy_s2), .q(y_d));
	j2g_delay #(.W(FN_W), .N(13)) u_dz (.clk(clk), .d(fz_s2), .q(z_d));
	j2g_fmul u_nx (.clk(clk), .a(x_d), .b(bx), .y(numx));
	j2g_fmul u_ny (.clk(clk), .a(y_d), .b(bx), .y(numy));
	j2g_fmul u_nz (.clk(clk), .a(z_d), .b(bz), .y(numz));
	j2g_delay #(.W(FN_W), .N(31)) u_dnx (.clk(clk), .d(numx), .q(numx_d));
	j2g_delay #(.W(FN_W), .N(31)) u_dny (.clk(clk), .d(numy), .q(numy_d));
	j2g_delay #(.W(FN_W), .N(29)) u_dnz (.clk(clk), .d(numz), .q(numz_d));

	j2g_fdiv u_divx (.clk(clk), .a(numx_d), .b(den), .y(quox));
	j2g_fdiv u_divy (.clk(clk), .a(numy_d), .b(den), .y(quoy));
	j2g_fdiv u_divz (.clk(clk), .a(numz_d), .b(den), .y(quoz));

	j2g_fmul u_ax (.clk(clk), .a(k_eff), .b(quox), .y(ax));
	j2g_fmul u_ay (.clk(clk), .a(k_eff), .b(quoy), .y(ay));
	j2g_fmul u_az (.clk(clk), .a(k_eff), .b(quoz), .y(az));

	j2g_delay #(.W(1), .N(VLD_N-1)) u_dzero (.clk(clk), .d(zero_s1), .q(zero_d));

	// truncate toward zero and saturate; top bit of the result is the saturation flag
	function automatic logic [ACC_WIDTH:0] to_out(input fnum_t v);
		logic [63:0]             limit, mag, sv;
		logic                    sat;
		logic signed [EXP_W-1:0] ne;
		limit = (64'd1 << (ACC_WIDTH-1)) - 64'd1 + {63'd0, v.s};
		ne    = -v.e;
		sat   = 1'b0;
		mag   = '0;
		if (v.m == '0) begin
			mag = '0;
		end else if (v.e >= EXP_W'(33)) begin
			mag = limit;
			sat = 1'b1;
		end else begin
			if (v.e >= EXP_W'(0)) mag = {32'd0, v.m} << v.e[5:0];
			else if (v.e <= EXP_W'(-32)) mag = '0;
			else mag = {32'd0, v.m} >> ne[5:0];
			if (mag > limit) begin
				mag = limit;
				sat = 1'b1;
			end
		end
		sv = v.s ? (~mag + 64'd1) : mag;
		return {sat, sv[ACC_WIDTH-1:0]};
	endfunction

	assign ox = to_out(ax);
	assign oy = to_out(ay);
	assign oz = to_out(az);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_q[VLD_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (zero_d) begin
			acc_x      <= {1'b0, {(ACC_WIDTH-1){1'b1}}};
			acc_y      <= {1'b0, {(ACC_WIDTH-1){1'b1}}};
			acc_z      <= {1'b0, {(ACC_WIDTH-1){1'b1}}};
			calc_error <= 1'b1;
		end else begin
			acc_x      <= ox[ACC_WIDTH-1:0];
			acc_y      <= oy[ACC_WIDTH-1:0];
			acc_z      <= oz[ACC_WIDTH-1:0];
			calc_error <= ox[ACC_WIDTH] | oy[ACC_WIDTH] | oz[ACC_WIDTH];
		end
	end

	a_every_item: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##83 done)
		else $error("transaction without result");

	a_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && pos_x == '0 && pos_y == '0 && pos_z == '0
		|-> ##83 (done && calc_error))
		else $error("zero position not flagged");

	a_cfg_grav: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == CFG_GRAV |=> grav_q == $past(cfg_data))
		else $error("grav_param write lost");
endmodule
